FILE: hw/rtl/wrs_pkg.sv
package wrs_pkg;

  // Fixed result and accumulator widths
  localparam int SUM_W  = 40;
  localparam int SQ_W   = 64;
  localparam int PROD_W = 80;
  localparam int DIV_W  = 96;
  localparam int DEN_W  = 32;
  localparam int ROOT_W = 40;
  localparam int MEAN_W = 56;
  localparam int VAR_W  = 62;
  localparam int LEN_W  = 16;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 7;

  // Iteration counts of the shared units
  localparam logic [STEP_W-1:0] SumMulSteps = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] DivSteps    = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] SqrtSteps   = STEP_W'(ROOT_W);

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD_A,
    OP_MUL_STEP,
    OP_LOAD_B,
    OP_LOAD_D,
    OP_LOAD_MEAN,
    OP_DIV_STEP,
    OP_LOAD_VAR,
    OP_LOAD_SQRT,
    OP_SQRT_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/wrs_ctrl.sv
module wrs_ctrl #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrs_pkg::dp_status_t status,
  output wrs_pkg::dp_cmd_t    cmd
);
  import wrs_pkg::*;

  localparam logic [STEP_W-1:0] CountSteps = STEP_W'(COUNT_BITS);

  typedef enum logic [14:0] {
    S_RUN       = 15'b000000000000001,
    S_DRAIN     = 15'b000000000000010,
    S_LOAD_A    = 15'b000000000000100,
    S_MUL_A     = 15'b000000000001000,
    S_LOAD_B    = 15'b000000000010000,
    S_MUL_B     = 15'b000000000100000,
    S_LOAD_D    = 15'b000000001000000,
    S_MUL_D     = 15'b000000010000000,
    S_LOAD_MEAN = 15'b000000100000000,
    S_DIV_MEAN  = 15'b000001000000000,
    S_LOAD_VAR  = 15'b000010000000000,
    S_DIV_VAR   = 15'b000100000000000,
    S_LOAD_SQRT = 15'b001000000000000,
    S_SQRT      = 15'b010000000000000,
    S_FINISH    = 15'b100000000000000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic              steps_done;

  assign steps_done = (steps == '0);
  assign in_ready   = (state == S_RUN);

  // Accept samples, then sequence the finalize steps
  always_comb begin
    state_next = state;
    steps_next = steps;
    cmd.op     = OP_IDLE;
    cmd.take   = 1'b0;
    unique case (state)
      S_RUN: begin
        cmd.take = in_valid;
        if (in_valid && status.last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_LOAD_A;
      S_LOAD_A: begin
        cmd.op     = OP_LOAD_A;
        steps_next = CountSteps - 1'b1;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_LOAD_B;
      end
      S_LOAD_B: begin
        cmd.op     = OP_LOAD_B;
        steps_next = SumMulSteps - 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_LOAD_D;
      end
      S_LOAD_D: begin
        cmd.op     = OP_LOAD_D;
        steps_next = CountSteps - 1'b1;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = OP_MUL_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_LOAD_MEAN;
      end
      S_LOAD_MEAN: begin
        cmd.op     = OP_LOAD_MEAN;
        steps_next = DivSteps - 1'b1;
        state_next = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        cmd.op     = OP_DIV_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_LOAD_VAR;
      end
      S_LOAD_VAR: begin
        cmd.op     = OP_LOAD_VAR;
        steps_next = DivSteps - 1'b1;
        state_next = S_DIV_VAR;
      end
      S_DIV_VAR: begin
        cmd.op     = OP_DIV_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_LOAD_SQRT;
      end
      S_LOAD_SQRT: begin
        cmd.op     = OP_LOAD_SQRT;
        steps_next = SqrtSteps - 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op     = OP_SQRT_STEP;
        steps_next = steps - 1'b1;
        if (steps_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
    end
  end

endmodule

FILE: hw/rtl/wrs_datapath.sv
module wrs_datapath #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wrs_pkg::LEN_W-1:0]         cfg_data,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  wrs_pkg::dp_cmd_t                  cmd,
  output wrs_pkg::dp_status_t               status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [SAMPLE_BITS-1:0]            min_value,
  output logic [SAMPLE_BITS-1:0]            max_value,
  output logic [wrs_pkg::SUM_W-1:0]         total,
  output logic [wrs_pkg::MEAN_W-1:0]        mean_q16,
  output logic [wrs_pkg::VAR_W-1:0]         variance_q16,
  output logic [wrs_pkg::ROOT_W-1:0]        deviation_q16
);
  import wrs_pkg::*;

  localparam logic [LEN_W-1:0] CountMax = LEN_W'((1 << COUNT_BITS) - 1);
  localparam logic [LEN_W-1:0] MinLen   = LEN_W'(2);

  // Window state
  logic [LEN_W-1:0]         window_len;
  logic [COUNT_BITS-1:0]    count;
  logic [SUM_W-1:0]         sum;
  logic [SQ_W-1:0]          sumsq;
  logic [SAMPLE_BITS-1:0]   run_min, run_max, x_reg;
  logic                     x_valid;
  logic [2*SAMPLE_BITS-1:0] sq;

  // Finalize state
  logic [PROD_W-1:0] acc, mcand, prod_a, dval;
  logic [SUM_W-1:0]  mplier;
  logic [DIV_W-1:0]  num;
  logic [DEN_W-1:0]  rem, den, den_var;
  logic [MEAN_W-1:0] mean_reg;
  logic [VAR_W-1:0]  var_reg;
  logic [PROD_W-1:0] sx;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+1:0] srem;

  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W:0]    cnt_inc;
  logic [DEN_W:0]    rem_sh;
  logic              div_ge;
  logic [ROOT_W+3:0] srem_sh, trial;
  logic              sqrt_ge;
  logic [VAR_W-1:0]  var_sat;

  assign sq = x_reg * x_reg;

  // Clamp the window length to the usable range
  always_comb begin
    priority if (window_len < MinLen) eff_len = MinLen;
    else if (window_len > CountMax) eff_len = CountMax;
    else eff_len = window_len;
  end

  assign cnt_inc         = (LEN_W+1)'(count) + 1'b1;
  assign status.last     = (cnt_inc >= {1'b0, eff_len});
  assign status.out_free = !out_valid || out_ready;

  // One restoring division step and one square root digit
  assign rem_sh  = {rem, num[DIV_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, den});
  assign srem_sh = {srem, sx[PROD_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sqrt_ge = (srem_sh >= trial);
  assign var_sat = (num[DIV_W-1:VAR_W] != '0) ? '1 : num[VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_W'(100);
    end else if (cfg_we) begin
      window_len <= cfg_data;
    end
  end

  // Register the sample, then fold it into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      count   <= '0;
      sum     <= '0;
      sumsq   <= '0;
      run_min <= '1;
      run_max <= '0;
    end else begin
      x_valid <= cmd.take;
      if (cmd.take) count <= count + 1'b1;
      if (x_valid) begin
        sum   <= sum + SUM_W'(x_reg);
        sumsq <= sumsq + SQ_W'(sq);
        if (x_reg < run_min) run_min <= x_reg;
        if (x_reg > run_max) run_max <= x_reg;
      end
      if (cmd.op == OP_FINISH) begin
        count   <= '0;
        sum     <= '0;
        sumsq   <= '0;
        run_min <= '1;
        run_max <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) x_reg <= sample;
  end

  // Shift-add multiplier, divider and square root
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD_A: begin
        acc    <= '0;
        mcand  <= PROD_W'(sumsq);
        mplier <= SUM_W'(count);
      end
      OP_MUL_STEP: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= mplier >> 1;
      end
      OP_LOAD_B: begin
        prod_a <= acc;
        acc    <= '0;
        mcand  <= PROD_W'(sum);
        mplier <= sum;
      end
      OP_LOAD_D: begin
        dval   <= (prod_a >= acc) ? prod_a - acc : '0;
        acc    <= '0;
        mcand  <= PROD_W'(count);
        mplier <= SUM_W'(count) - 1'b1;
      end
      OP_LOAD_MEAN: begin
        den_var <= acc[DEN_W-1:0];
        den     <= DEN_W'(count);
        num     <= DIV_W'({sum, {FRAC_W{1'b0}}});
        rem     <= '0;
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        num <= {num[DIV_W-2:0], div_ge};
      end
      OP_LOAD_VAR: begin
        mean_reg <= num[MEAN_W-1:0];
        den      <= den_var;
        num      <= {dval, {FRAC_W{1'b0}}};
        rem      <= '0;
      end
      OP_LOAD_SQRT: begin
        var_reg <= var_sat;
        sx      <= {2'b00, var_sat, {FRAC_W{1'b0}}};
        root    <= '0;
        srem    <= '0;
      end
      OP_SQRT_STEP: begin
        srem <= sqrt_ge ? (ROOT_W+2)'(srem_sh - trial) : srem_sh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], sqrt_ge};
        sx   <= {sx[PROD_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      min_value     <= run_min;
      max_value     <= run_max;
      total         <= sum;
      mean_q16      <= mean_reg;
      variance_q16  <= var_reg;
      deviation_q16 <= root;
    end
  end

endmodule

FILE: hw/rtl/window_running_statistics.sv
// Windowed statistics over unsigned samples.
// Samples enter on the in_valid/in_ready channel, one per cycle while a
// window is filling. Each window of window_len samples (clamped to
// 2 .. 2^COUNT_BITS-1) yields one result item on out_valid/out_ready:
// min, max, exact sum, and Q.16 mean, sample variance and deviation.
// The window length is written on the cfg_valid/cfg_ready channel, which
// is always ready; write it only while the block is idle.
// After the last sample of a window, in_ready drops while a shared
// shift-add multiplier, a restoring divider (one quotient bit a cycle)
// and a square root unit (one root bit a cycle) run in turn.
// The result sits in an output register; the next window fills while it
// waits. If the receiver still stalls at the next window end, the block
// holds the finished result and keeps in_ready low until it is taken.
// Reset (synchronous, rst high) empties the window, drops out_valid and
// sets window_len to 100.
module window_running_statistics #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wrs_pkg::LEN_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            min_value,
  output logic [SAMPLE_BITS-1:0]            max_value,
  output logic [wrs_pkg::SUM_W-1:0]         total,
  output logic [wrs_pkg::MEAN_W-1:0]        mean_q16,
  output logic [wrs_pkg::VAR_W-1:0]         variance_q16,
  output logic [wrs_pkg::ROOT_W-1:0]        deviation_q16
);
  import wrs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  wrs_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wrs_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .min_value    (min_value),
    .max_value    (max_value),
    .total        (total),
    .mean_q16     (mean_q16),
    .variance_q16 (variance_q16),
    .deviation_q16(deviation_q16)
  );

endmodule

FILE: bench/window_stats_checker.sv
module window_stats_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [23:0] sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] min_value,
  input  logic [23:0] max_value,
  input  logic [39:0] total,
  input  logic [55:0] mean_q16,
  input  logic [61:0] variance_q16,
  input  logic [39:0] deviation_q16,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [61:0] VarSat = {62{1'b1}};

  typedef struct packed {
    logic [23:0] mn;
    logic [23:0] mx;
    logic [39:0] tot;
    logic [55:0] mean;
    logic [61:0] vq;
    logic [39:0] dev;
  } window_stats_t;

  window_stats_t stats_q[$];

  // Shadow copy of the window state
  logic [15:0] win_len;
  logic [15:0] cnt;
  logic [39:0] acc_sum;
  logic [63:0] acc_sq;
  logic [23:0] acc_min;
  logic [23:0] acc_max;

  function automatic logic [39:0] floor_root(logic [79:0] x);
    logic [79:0] r;
    logic [79:0] c;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      c = r | (80'd1 << b);
      if (c * c <= x) r = c;
    end
    return r[39:0];
  endfunction

  // Close a window: derive mean, variance and deviation
  function automatic window_stats_t close_window();
    window_stats_t s;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] d;
    logic [127:0] q;
    logic [63:0]  den;
    logic [63:0]  n;
    n = {48'd0, cnt};
    s.mn = acc_min;
    s.mx = acc_max;
    s.tot = acc_sum;
    s.mean = 56'(({24'd0, acc_sum} << 16) / n);
    a = 128'(n) * 128'(acc_sq);
    b = 128'(acc_sum) * 128'(acc_sum);
    d = (a < b) ? '0 : a - b;
    d = d << 16;
    den = n * (n - 64'd1);
    q = d / 128'(den);
    s.vq = (q > 128'(VarSat)) ? VarSat : q[61:0];
    s.dev = floor_root({s.vq, 16'd0});
    return s;
  endfunction

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  assign pending = stats_q.size();

  always @(posedge clk) begin
    window_stats_t e;
    logic [15:0] eff;
    if (rst) begin
      win_len = 16'd100;
      cnt = '0;
      acc_sum = '0;
      acc_sq = '0;
      acc_min = '1;
      acc_max = '0;
      errors = 0;
      stats_q.delete();
    end else begin
      // Track length writes
      if (cfg_valid && cfg_ready) win_len = cfg_data;

      // Accumulate an accepted item; close the window when it is full
      if (in_valid && in_ready) begin
        cnt = cnt + 16'd1;
        acc_sum = acc_sum + 40'(sample);
        acc_sq = acc_sq + 64'(sample) * 64'(sample);
        if (sample < acc_min) acc_min = sample;
        if (sample > acc_max) acc_max = sample;
        eff = (win_len < 16'd2) ? 16'd2 : win_len;
        if (cnt >= eff) begin
          stats_q.push_back(close_window());
          cnt = '0;
          acc_sum = '0;
          acc_sq = '0;
          acc_min = '1;
          acc_max = '0;
        end
      end

      // Compare a delivered result with the oldest expectation
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          $display("%0t: result with no window pending", $time);
          errors++;
        end else begin
          e = stats_q.pop_front();
          check_field("min_value", 64'(e.mn), 64'(min_value));
          check_field("max_value", 64'(e.mx), 64'(max_value));
          check_field("total", 64'(e.tot), 64'(total));
          check_field("mean_q16", 64'(e.mean), 64'(mean_q16));
          check_field("variance_q16", 64'(e.vq), 64'(variance_q16));
          check_field("deviation_q16", 64'(e.dev), 64'(deviation_q16));
        end
      end
    end
  end
endmodule

FILE: bench/tb_window_running_statistics.sv
module tb_window_running_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 400;
  localparam int StallLimit  = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] sample;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] min_value;
  logic [23:0] max_value;
  logic [39:0] total;
  logic [55:0] mean_q16;
  logic [61:0] variance_q16;
  logic [39:0] deviation_q16;
  int          pending;
  int          errors;
  int          idle_pct;
  int          stall_pct;
  int          quiet;

  window_running_statistics dut (.*);

  window_stats_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(logic [23:0] x);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    sample <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold input until all windows have reported, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_len(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 24'($urandom_range(15));
      3: return 24'hFFFFF0 | 24'($urandom_range(15));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: variance saturation, flat windows, short lengths
    write_len(16'd2);
    send('0); send('1);
    send('0); send('0);
    send('1); send('1);
    write_len(16'd0);
    send(24'd1); send(24'd2);
    write_len(16'd1);
    send(24'd5); send(24'd7);
    write_len(16'd3);
    send(24'd1); send(24'd2); send(24'd4);
    // Longest length, then shrink mid window so the next item closes it
    write_len(16'hFFFF);
    send(24'h800000); send(24'h7FFFFF); send(24'd9);
    write_len(16'd4);
    send(24'd3);
    send(24'd10); send(24'd20); send(24'd30); send(24'd40);
    write_len(16'd100);
    for (int i = 0; i < 100; i++) send(pick_sample());

    // Random windows under each flow-control mix
    for (int mode = 0; mode < 4; mode++) begin
      drain();
      idle_pct = (mode == 1) ? 81 : (mode == 3) ? 17 : 0;
      stall_pct = (mode == 2) ? 81 : (mode == 3) ? 17 : 0;
      sent = 0;
      while (sent < 110) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
        write_len(16'(len));
        repeat (len * $urandom_range(1, 3)) begin
          send(pick_sample());
          sent++;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
